FILE: rtl/pll_pkg.sv
// Package for the lexical scanner: scan modes, token tags, character codes.
// No dependencies.
package pll_pkg;

   typedef enum logic [2:0] {
      MODE_START = 3'd0,
      MODE_INT   = 3'd1,
      MODE_FLOAT = 3'd2,
      MODE_IDENT = 3'd3,
      MODE_STR   = 3'd4,
      MODE_COLON = 3'd5,
      MODE_LT    = 3'd6,
      MODE_GT    = 3'd7
   } mode_type;

   localparam logic [5:0] TAG_SEMI   = 6'd0;
   localparam logic [5:0] TAG_OPEN   = 6'd1;
   localparam logic [5:0] TAG_CLOSE  = 6'd2;
   localparam logic [5:0] TAG_COMMA  = 6'd3;
   localparam logic [5:0] TAG_BIND   = 6'd4;
   localparam logic [5:0] TAG_COLON  = 6'd5;
   localparam logic [5:0] TAG_CONCAT = 6'd6;
   localparam logic [5:0] TAG_ADD    = 6'd7;
   localparam logic [5:0] TAG_SUB    = 6'd8;
   localparam logic [5:0] TAG_MUL    = 6'd9;
   localparam logic [5:0] TAG_DIV    = 6'd10;
   localparam logic [5:0] TAG_LE     = 6'd11;
   localparam logic [5:0] TAG_NE     = 6'd12;
   localparam logic [5:0] TAG_LT     = 6'd13;
   localparam logic [5:0] TAG_GE     = 6'd14;
   localparam logic [5:0] TAG_GT     = 6'd15;
   localparam logic [5:0] TAG_EQ     = 6'd16;
   localparam logic [5:0] TAG_INT    = 6'd17;
   localparam logic [5:0] TAG_FLOAT  = 6'd18;
   localparam logic [5:0] TAG_STRING = 6'd19;
   localparam logic [5:0] TAG_IDENT  = 6'd20;
   localparam logic [5:0] TAG_FINISH = 6'd21;

   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_END  = 1'b1;
   localparam logic KIND_ECHO  = 1'b0;
   localparam logic KIND_TOKEN = 1'b1;

   localparam int KW_COUNT = 30;
   localparam int KW_MAX   = 9;   // longest keyword

   // Classified character event handed from front to back.
   typedef struct packed {
      logic       is_end;
      logic [7:0] ch;
   } event_type;

   // One result word.
   typedef struct packed {
      logic        kind;
      logic [7:0]  text_char;
      logic [5:0]  token_tag;
      logic [15:0] line_number;
      logic        last;
   } result_type;

   function automatic logic [8*KW_MAX-1:0] kw_name(input int i);
      logic [8*KW_MAX-1:0] s;
      begin
         unique case (i)
            0:  s = "program";   1:  s = "if";       2:  s = "else";
            3:  s = "while";     4:  s = "case";     5:  s = "repeat";
            6:  s = "until";     7:  s = "do";       8:  s = "break";
            9:  s = "function";  10: s = "procedure"; 11: s = "begin";
            12: s = "end";       13: s = "int";      14: s = "bool";
            15: s = "char";      16: s = "float";    17: s = "string";
            18: s = "or";        19: s = "and";      20: s = "then";
            21: s = "of";        22: s = "var";      23: s = "type";
            24: s = "for";       25: s = "to";       26: s = "downto";
            27: s = "record";    28: s = "const";    default: s = "forword";
         endcase
         return s;
      end
   endfunction

   function automatic logic [3:0] kw_len(input int i);
      logic [3:0] n;
      begin
         unique case (i)
            0, 29:                      n = 4'd7;
            1, 7, 18, 21, 25:           n = 4'd2;
            2, 4, 14, 15, 20, 23:       n = 4'd4;
            3, 6, 8, 11, 16, 28:        n = 4'd5;
            5, 17, 26, 27:              n = 4'd6;
            9:                          n = 4'd8;
            10:                         n = 4'd9;
            default:                    n = 4'd3;
         endcase
         return n;
      end
   endfunction

   function automatic logic [5:0] kw_tag(input int i);
      logic [5:0] t;
      begin
         unique case (i)
            13:      t = TAG_INT;
            16:      t = TAG_FLOAT;
            17:      t = TAG_STRING;
            default: t = (i < 13) ? 6'(22 + i) : (i < 16) ? 6'(21 + i) : 6'(19 + i);
         endcase
         return t;
      end
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction
   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction
   function automatic logic is_space(input logic [7:0] c);
      return c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A;
   endfunction
   function automatic logic is_delim(input logic [7:0] c);
      return c == "," || c == "(" || c == ")" || c == "[" || c == "]" || c == ";" ||
             c == ":" || c == "=" || c == "<" || c == ">" || c == "+" || c == "-" ||
             c == "*" || c == "/" || c == "&";
   endfunction

endpackage

FILE: rtl/pll_stream_if.sv
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; payload type is a parameter.
interface pll_stream_if #(parameter type payload_type = logic [8:0]);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/pll_front.sv
// Front end: takes input words into a two-entry queue toward the back end.
// Depends on pll_pkg.
module pll_front
   import pll_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  event_type in_event,
   output logic      ev_valid,
   input  logic      ev_take,
   output event_type ev_head
);
   event_type  q_ff [2];
   event_type  q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign in_ready = cnt_ff != 2'd2;
   assign push     = in_valid && in_ready;
   assign ev_valid = cnt_ff != 2'd0;
   assign ev_head  = q_ff[0];

   always_comb begin
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (ev_take) begin
         q_in[0] = q_ff[1];
         cnt_in  = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = in_event;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) cnt_ff <= 2'd0;
      else       cnt_ff <= cnt_in;
   end
endmodule

FILE: rtl/pll_back.sv
// Back end: scan state machine producing up to three result words per event,
// drained one per cycle while out_ready is high. Depends on pll_pkg.
module pll_back
   import pll_pkg::*;
#(
   parameter int LINE_BITS     = 16,
   parameter int KEYWORD_CHARS = 9
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       ev_valid,
   output logic       ev_take,
   input  event_type  ev_head,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_word
);
   localparam int LEN_BITS = $clog2(KEYWORD_CHARS + 2);
   localparam int IDX_BITS = $clog2(KEYWORD_CHARS);
   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;

   mode_type               mode_ff, mode_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [7:0]             word_ff [KEYWORD_CHARS];
   logic [7:0]             word_in [KEYWORD_CHARS];
   logic [LEN_BITS-1:0]    len_ff, len_in;

   // result buffer: up to four words, drained from index 0
   result_type buf_ff [4];
   result_type buf_in [4];
   logic [2:0] bcnt_ff, bcnt_in;
   logic [1:0] bptr_ff, bptr_in;

   result_type res [4];
   logic [2:0] nres;
   logic [5:0] wtag;
   logic [7:0] c;
   logic       drained;

   assign c        = ev_head.ch;
   assign drained  = (bcnt_ff == 3'd0) ||
                     (bcnt_ff == {1'b0, bptr_ff} + 3'd1 && out_ready);
   assign ev_take  = ev_valid && drained;
   assign out_valid = bcnt_ff != 3'd0;
   assign out_word  = buf_ff[bptr_ff];

   // keyword lookup over the stored word
   always_comb begin
      logic hit;
      logic [8*KW_MAX-1:0] nm;
      wtag = TAG_IDENT;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         nm  = kw_name(i);
         hit = len_ff == LEN_BITS'(kw_len(i));
         for (int k = 0; k < KW_MAX; k++)
            if (k < int'(kw_len(i)) && word_ff[k] != nm[8*(int'(kw_len(i))-1-k) +: 8])
               hit = 1'b0;
         if (hit) wtag = kw_tag(i);
      end
   end

   always_comb begin
      logic rescan;
      mode_in = mode_ff;
      line_in = line_ff;
      word_in = word_ff;
      len_in  = len_ff;
      nres    = 3'd0;
      rescan  = 1'b0;
      for (int i = 0; i < 4; i++) res[i] = '0;

      if (ev_head.is_end) begin
         res[0].kind = KIND_TOKEN;
         res[0].token_tag = TAG_FINISH;
         res[0].line_number = 16'(line_ff == LINE_MAX ? line_ff : line_ff + 1'b1);
         nres = 3'd1;
         mode_in = MODE_START;
         line_in = LINE_BITS'(1);
         len_in  = '0;
      end else begin
         unique case (mode_ff)
            MODE_INT, MODE_FLOAT: begin
               if (mode_ff == MODE_INT && c == ".") begin
                  res[0].text_char = c; nres = 3'd1; mode_in = MODE_FLOAT;
               end else if (is_digit(c)) begin
                  res[0].text_char = c; nres = 3'd1;
               end else if (is_delim(c) || is_space(c)) begin
                  res[0].kind = KIND_TOKEN;
                  res[0].token_tag = (mode_ff == MODE_INT) ? TAG_INT : TAG_FLOAT;
                  res[0].line_number = 16'(line_ff);
                  nres = 3'd1; rescan = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (is_letter(c) || is_digit(c)) begin
                  res[0].text_char = c; nres = 3'd1;
                  if (len_ff < LEN_BITS'(KEYWORD_CHARS))
                     word_in[len_ff[IDX_BITS-1:0]] = c;
                  if (len_ff <= LEN_BITS'(KEYWORD_CHARS)) len_in = len_ff + 1'b1;
               end else if (is_delim(c) || is_space(c)) begin
                  res[0].kind = KIND_TOKEN;
                  res[0].token_tag = wtag;
                  res[0].line_number = 16'(line_ff);
                  nres = 3'd1; rescan = 1'b1;
               end
            end
            MODE_STR: begin
               if (c == "\"") begin
                  res[0].kind = KIND_TOKEN; res[0].token_tag = TAG_STRING;
                  res[0].line_number = 16'(line_ff);
                  mode_in = MODE_START;
               end else res[0].text_char = c;
               nres = 3'd1;
            end
            MODE_COLON, MODE_LT, MODE_GT: begin
               if (c == "=" || (mode_ff == MODE_LT && c == ">")) begin
                  res[0].text_char = c;
                  res[1].kind = KIND_TOKEN;
                  res[1].line_number = 16'(line_ff);
                  res[1].token_tag = (mode_ff == MODE_COLON) ? TAG_BIND :
                                     (mode_ff == MODE_GT) ? TAG_GE :
                                     (c == "=") ? TAG_LE : TAG_NE;
                  nres = 3'd2; mode_in = MODE_START;
               end else begin
                  res[0].kind = KIND_TOKEN;
                  res[0].line_number = 16'(line_ff);
                  res[0].token_tag = (mode_ff == MODE_COLON) ? TAG_COLON :
                                     (mode_ff == MODE_LT) ? TAG_LT : TAG_GT;
                  nres = 3'd1; rescan = 1'b1;
               end
            end
            default: rescan = 1'b1;
         endcase

         // start-mode scan of the character, after any token above
         if (rescan) begin
            mode_in = MODE_START;
            if (c == 8'h0A) begin
               if (line_ff != LINE_MAX) line_in = line_ff + 1'b1;
            end else if (is_space(c)) begin
            end else if (c == "\"") begin
               mode_in = MODE_STR;
            end else begin
               res[nres[1:0]].kind = KIND_ECHO;
               res[nres[1:0]].text_char = c;
               res[nres[1:0]].token_tag = '0;
               res[nres[1:0]].line_number = '0;
               nres = nres + 3'd1;
               if (is_digit(c)) mode_in = MODE_INT;
               else if (is_letter(c)) begin
                  mode_in = MODE_IDENT;
                  word_in[0] = c;
                  len_in = LEN_BITS'(1);
               end else if (c == ":") mode_in = MODE_COLON;
               else if (c == "<") mode_in = MODE_LT;
               else if (c == ">") mode_in = MODE_GT;
               else if (c == ";" || c == "(" || c == ")" || c == "," || c == "&" ||
                        c == "+" || c == "-" || c == "*" || c == "/" || c == "=") begin
                  res[nres[1:0]].kind = KIND_TOKEN;
                  res[nres[1:0]].line_number = 16'(line_ff);
                  priority case (c)
                     ";": res[nres[1:0]].token_tag = TAG_SEMI;
                     "(": res[nres[1:0]].token_tag = TAG_OPEN;
                     ")": res[nres[1:0]].token_tag = TAG_CLOSE;
                     ",": res[nres[1:0]].token_tag = TAG_COMMA;
                     "&": res[nres[1:0]].token_tag = TAG_CONCAT;
                     "+": res[nres[1:0]].token_tag = TAG_ADD;
                     "-": res[nres[1:0]].token_tag = TAG_SUB;
                     "*": res[nres[1:0]].token_tag = TAG_MUL;
                     "/": res[nres[1:0]].token_tag = TAG_DIV;
                     default: res[nres[1:0]].token_tag = TAG_EQ;
                  endcase
                  nres = nres + 3'd1;
               end
            end
         end
      end
      if (nres != 3'd0) res[nres[1:0] - 2'd1].last = 1'b1;
   end

   always_comb begin
      buf_in  = buf_ff;
      bcnt_in = bcnt_ff;
      bptr_in = bptr_ff;
      if (out_valid && out_ready) begin
         if ({1'b0, bptr_ff} + 3'd1 == bcnt_ff) begin
            bcnt_in = 3'd0; bptr_in = 2'd0;
         end else bptr_in = bptr_ff + 2'd1;
      end
      if (ev_take) begin
         buf_in  = res;
         bcnt_in = nres;
         bptr_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      buf_ff  <= buf_in;
      if (reset) begin
         mode_ff <= MODE_START;
         line_ff <= LINE_BITS'(1);
         len_ff  <= '0;
         bcnt_ff <= 3'd0;
         bptr_ff <= 2'd0;
      end else begin
         if (ev_take) begin
            mode_ff <= mode_in;
            line_ff <= line_in;
            len_ff  <= len_in;
         end
         bcnt_ff <= bcnt_in;
         bptr_ff <= bptr_in;
      end
   end
endmodule

FILE: rtl/pascal_like_lexer.sv
// Pascal-like lexical scanner: one source character per word in, echo and token words out.
// Words are registered in the front queue, then the back result buffer. One word per cycle
// sustained when each word yields one result and rsp is ready, else drain-port limited.
// Reset (synchronous, active high) empties the queues, enters start mode, line count 1.
// Depends on pll_pkg, pll_stream_if, pll_front, pll_back.
module pascal_like_lexer
   import pll_pkg::*;
#(
   parameter int LINE_BITS     = 16,
   parameter int KEYWORD_CHARS = 9
) (
   input  logic clock,
   input  logic reset,
   pll_stream_if.sink   req,
   pll_stream_if.source rsp
);
   // req payload: {cmd, char_code}; rsp payload: result_type
   event_type  ev_head;
   event_type  in_event;
   logic       ev_valid;
   logic       ev_take;
   result_type out_word;

   assign in_event.is_end = req.payload[8] == CMD_END;
   assign in_event.ch     = req.payload[7:0];

   // front: input queue decoupling acceptance from scanning
   pll_front u_front (
      .clock, .reset,
      .in_valid (req.valid), .in_ready (req.ready), .in_event,
      .ev_valid, .ev_take, .ev_head
   );

   // back: scan state and result buffer
   pll_back #(.LINE_BITS(LINE_BITS), .KEYWORD_CHARS(KEYWORD_CHARS)) u_back (
      .clock, .reset, .ev_valid, .ev_take, .ev_head,
      .out_valid (rsp.valid), .out_ready (rsp.ready), .out_word
   );

   assign rsp.payload = out_word;
endmodule
